>>> hdl/htks_pkg.sv
// Shared types and constants for the histogram top-k shade selector.
// Has no dependencies. The top level uses it through scoped names.
`timescale 1ns / 1ps

package htks_pkg;

    // Sizes of the histogram and of the pick list.
    localparam int NUM_BINS    = 256;
    localparam int MAX_COLORS  = 16;
    localparam int COUNT_WIDTH = 20;

    localparam int SHADE_W = 8;
    localparam int RANK_W  = 4;
    localparam int NCOL_W  = 5;
    localparam int BIN_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int PICK_W  = $clog2(MAX_COLORS + 1);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [BIN_W-1:0]       LAST_BIN  = BIN_W'(NUM_BINS - 1);

    // Register index within the configuration space.
    localparam logic REG_NUM_COLORS = 1'b0;
    localparam logic [NCOL_W-1:0] NUM_COLORS_RESET = NCOL_W'(4);

    // One input request: a pixel shade and the end-of-image mark.
    typedef struct packed {
        logic [SHADE_W-1:0] shade;
        logic               last_pixel;
    } pixel_t;

    // One result request: a pick with its rank.
    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [SHADE_W-1:0] top_shade;
        logic               last_result;
    } result_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_ACCUM,
        ST_DRAIN,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT
    } state_t;

endpackage

>>> hdl/histogram_top_k_shades_top.sv
// Histogram top-k shade selector: counts pixel shades in a bin memory and
// reports the most frequent shades at the end of each image.
// Depends on htks_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_data) takes one pixel request
// per cycle while the block is accumulating. Each pixel is a read-modify-
// write of the bin memory: read at acceptance, incremented and written back
// in the next cycle, with the previous write forwarded when the same bin
// follows directly.
// The request marked last_pixel is counted, then in_stall rises and the
// block makes num_colors picks (0 counts as 1, values above 16 give 16).
// Each pick is a scan that reads all 256 bins through the single read port,
// one bin a cycle, and then hands the pick to the output register. The
// picked bin is zeroed and the pick goes out on out_valid, out_data with
// its rank; the final pick carries last_result. A stalled result holds in
// the output register and the next pick waits. After the last pick, a
// clearing pass writes zero to all 256 bins, one per cycle, before the next
// pixel is accepted. Reset starts the same clearing pass and sets
// num_colors to 4. The APB port holds num_colors at byte address 0;
// configuration writes are taken at any time.

module histogram_top_k_shades_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  htks_pkg::pixel_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output htks_pkg::result_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htks_pkg::PADDR_W-1:0]  paddr,
    input  logic [htks_pkg::PDATA_W-1:0]  pwdata,
    output logic [htks_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // Bin memory with a registered read port.
    logic [htks_pkg::COUNT_WIDTH-1:0] bin_mem [htks_pkg::NUM_BINS];
    logic [htks_pkg::COUNT_WIDTH-1:0] rd_data_reg;
    logic [htks_pkg::BIN_W-1:0]       rd_addr;
    logic                             wr_en;
    logic [htks_pkg::BIN_W-1:0]       wr_addr;
    logic [htks_pkg::COUNT_WIDTH-1:0] wr_data;

    htks_pkg::state_t state_reg, state_next;

    logic [htks_pkg::NCOL_W-1:0]      num_colors_reg;
    logic                             cfg_wr;

    // Accumulation pipeline and write forwarding.
    logic                             acc_valid_reg, acc_valid_next;
    logic [htks_pkg::BIN_W-1:0]       acc_addr_reg, acc_addr_next;
    logic                             fwd_valid_reg;
    logic [htks_pkg::BIN_W-1:0]       fwd_addr_reg;
    logic [htks_pkg::COUNT_WIDTH-1:0] fwd_data_reg;
    logic [htks_pkg::COUNT_WIDTH-1:0] acc_old;
    logic [htks_pkg::COUNT_WIDTH-1:0] acc_new;

    // Scan and pick bookkeeping.
    logic [htks_pkg::BIN_W-1:0]       cnt_reg, cnt_next;
    logic                             scan_valid_reg, scan_valid_next;
    logic [htks_pkg::BIN_W-1:0]       scan_addr_reg;
    logic [htks_pkg::COUNT_WIDTH-1:0] best_reg, best_next;
    logic [htks_pkg::BIN_W-1:0]       where_reg, where_next;
    logic [htks_pkg::PICK_W-1:0]      pick_reg, pick_next;
    logic [htks_pkg::PICK_W-1:0]      picks;
    logic                             pick_last;
    logic                             cnt_end;

    // Output register.
    logic                             out_valid_reg, out_valid_next;
    htks_pkg::result_t                out_data_reg, out_data_next;

    // Decoded control from the sequencer.
    logic                             in_accept;
    logic                             emit_fire;
    logic                             scan_start;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == htks_pkg::REG_NUM_COLORS);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == htks_pkg::REG_NUM_COLORS)
        begin
            prdata = htks_pkg::PDATA_W'(num_colors_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg <= htks_pkg::NUM_COLORS_RESET;
        end
        else if (cfg_wr)
        begin
            num_colors_reg <= pwdata[htks_pkg::NCOL_W-1:0];
        end
    end

    // Effective pick count: zero means one, large values saturate.
    always_comb
    begin
        if (num_colors_reg == '0)
        begin
            picks = htks_pkg::PICK_W'(1);
        end
        else if (32'(num_colors_reg) > 32'(htks_pkg::MAX_COLORS))
        begin
            picks = htks_pkg::PICK_W'(htks_pkg::MAX_COLORS);
        end
        else
        begin
            picks = htks_pkg::PICK_W'(num_colors_reg);
        end
    end

    assign pick_last = (pick_reg == picks - htks_pkg::PICK_W'(1));
    assign cnt_end   = (cnt_reg == htks_pkg::LAST_BIN);
    assign emit_fire = (state_reg == htks_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);
    assign in_accept = in_valid && !in_stall;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            htks_pkg::ST_CLEAR:
            begin
                if (cnt_end)
                begin
                    state_next = htks_pkg::ST_ACCUM;
                end
            end
            htks_pkg::ST_ACCUM:
            begin
                if (in_valid && in_data.last_pixel)
                begin
                    state_next = htks_pkg::ST_DRAIN;
                end
            end
            htks_pkg::ST_DRAIN:
            begin
                state_next = htks_pkg::ST_SCAN;
            end
            htks_pkg::ST_SCAN:
            begin
                if (cnt_end)
                begin
                    state_next = htks_pkg::ST_SCAN_END;
                end
            end
            htks_pkg::ST_SCAN_END:
            begin
                state_next = htks_pkg::ST_EMIT;
            end
            htks_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = pick_last ? htks_pkg::ST_CLEAR : htks_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = htks_pkg::ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs: handshake, memory port selection.
    always_comb
    begin
        in_stall   = 1'b1;
        scan_start = 1'b0;
        rd_addr    = cnt_reg;
        wr_en      = 1'b0;
        wr_addr    = acc_addr_reg;
        wr_data    = acc_new;
        case (state_reg)
            htks_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = '0;
            end
            htks_pkg::ST_ACCUM:
            begin
                in_stall = 1'b0;
                rd_addr  = htks_pkg::BIN_W'(in_data.shade);
                wr_en    = acc_valid_reg;
            end
            htks_pkg::ST_DRAIN:
            begin
                wr_en      = acc_valid_reg;
                scan_start = 1'b1;
            end
            htks_pkg::ST_SCAN:
            begin
                rd_addr = cnt_reg;
            end
            htks_pkg::ST_SCAN_END:
            begin
                rd_addr = cnt_reg;
            end
            htks_pkg::ST_EMIT:
            begin
                wr_en      = emit_fire;
                wr_addr    = where_reg;
                wr_data    = '0;
                scan_start = emit_fire && !pick_last;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Increment with forwarding of the write made in the previous cycle.
    assign acc_old = (fwd_valid_reg && (fwd_addr_reg == acc_addr_reg)) ? fwd_data_reg
                                                                        : rd_data_reg;
    assign acc_new = (acc_old == htks_pkg::COUNT_MAX) ? acc_old
                                                       : acc_old + htks_pkg::COUNT_WIDTH'(1);

    // Datapath next values: accumulation, scan compare, picks, output.
    always_comb
    begin
        acc_valid_next  = in_accept && (32'(in_data.shade) < 32'(htks_pkg::NUM_BINS));
        acc_addr_next   = htks_pkg::BIN_W'(in_data.shade);
        cnt_next        = cnt_reg;
        scan_valid_next = (state_reg == htks_pkg::ST_SCAN);
        best_next       = best_reg;
        where_next      = where_reg;
        pick_next       = pick_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        // Running maximum, ties go to the higher bin.
        if (scan_valid_reg && (rd_data_reg >= best_reg))
        begin
            best_next  = rd_data_reg;
            where_next = scan_addr_reg;
        end

        if ((state_reg == htks_pkg::ST_CLEAR) || (state_reg == htks_pkg::ST_SCAN))
        begin
            cnt_next = cnt_reg + htks_pkg::BIN_W'(1);
        end

        if (scan_start)
        begin
            cnt_next  = '0;
            best_next = '0;
        end

        if (emit_fire)
        begin
            out_valid_next            = 1'b1;
            out_data_next.rank        = htks_pkg::RANK_W'(pick_reg);
            out_data_next.top_shade   = htks_pkg::SHADE_W'(where_reg);
            out_data_next.last_result = pick_last;
            pick_next = pick_last ? '0 : pick_reg + htks_pkg::PICK_W'(1);
            if (pick_last)
            begin
                cnt_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htks_pkg::ST_CLEAR;
            cnt_reg        <= '0;
            acc_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            scan_valid_reg <= 1'b0;
            pick_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            acc_valid_reg  <= acc_valid_next;
            fwd_valid_reg  <= acc_valid_reg;
            scan_valid_reg <= scan_valid_next;
            pick_reg       <= pick_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_addr_reg  <= acc_addr_next;
        fwd_addr_reg  <= acc_addr_reg;
        fwd_data_reg  <= acc_new;
        scan_addr_reg <= cnt_reg;
        best_reg      <= best_next;
        where_reg     <= where_next;
        out_data_reg  <= out_data_next;
    end

    // Bin memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Pixel updates never overlap a scan or a clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid_reg |-> (state_reg == htks_pkg::ST_ACCUM) || (state_reg == htks_pkg::ST_DRAIN))
        else $error("pixel update outside accumulation");

    // Scan compares only run while a scan is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid_reg |-> (state_reg == htks_pkg::ST_SCAN) ||
                           (state_reg == htks_pkg::ST_SCAN_END))
        else $error("scan compare outside scan");

    // A last pixel stops intake and starts the drain cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.last_pixel) |=> (state_reg == htks_pkg::ST_DRAIN) && in_stall)
        else $error("last pixel did not start selection");

    // The final pick is followed by the clearing pass from bin zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && pick_last) |=> (state_reg == htks_pkg::ST_CLEAR) && (cnt_reg == '0)
                                     && out_data_reg.last_result)
        else $error("final pick did not start clearing");

endmodule

>>> tb/sv/htks_pick_checker.sv
// Checker for the histogram top-k shade selector: watches the pixel, pick and APB channels.
// Keeps its own histogram and pick count, and compares each pick with the predicted one.
// Depends on htks_pkg.
`timescale 1ns / 1ps

module htks_pick_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  htks_pkg::pixel_t              in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  htks_pkg::result_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [htks_pkg::PADDR_W-1:0]  paddr,
    input  logic [htks_pkg::PDATA_W-1:0]  pwdata,
    output int                            mismatches,
    output int                            waiting
);

    // Predicted histogram, pick count and the picks still to come.
    logic [htks_pkg::COUNT_WIDTH-1:0] tally [htks_pkg::NUM_BINS];
    logic [htks_pkg::NCOL_W-1:0]      pick_limit;
    htks_pkg::result_t                due_picks [$];

    initial
    begin
        mismatches = 0;
        waiting    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Counts one pixel request. A request marked last runs the picks and clears the bins.
    task automatic count_pixel(input htks_pkg::pixel_t px);
        int                               picks;
        int                               best_bin;
        logic [htks_pkg::COUNT_WIDTH-1:0] best;
        htks_pkg::result_t                pick;
        if (int'(px.shade) < htks_pkg::NUM_BINS && tally[px.shade] != htks_pkg::COUNT_MAX)
            tally[px.shade] = tally[px.shade] + htks_pkg::COUNT_WIDTH'(1);
        if (px.last_pixel)
        begin
            picks = (pick_limit == '0) ? 1 : int'(pick_limit);
            if (picks > htks_pkg::MAX_COLORS)
                picks = htks_pkg::MAX_COLORS;
            for (int i = 0; i < picks; i++)
            begin
                // Ties go to the highest bin, so emptied bins come from the top down.
                best     = '0;
                best_bin = 0;
                for (int j = 0; j < htks_pkg::NUM_BINS; j++)
                begin
                    if (tally[j] >= best)
                    begin
                        best     = tally[j];
                        best_bin = j;
                    end
                end
                tally[best_bin]  = '0;
                pick.rank        = htks_pkg::RANK_W'(i);
                pick.top_shade   = htks_pkg::SHADE_W'(best_bin);
                pick.last_result = (i + 1 == picks);
                due_picks.push_back(pick);
            end
            for (int j = 0; j < htks_pkg::NUM_BINS; j++)
                tally[j] = '0;
        end
    endtask

    // Compares one accepted pick request with the oldest prediction.
    task automatic check_pick(input htks_pkg::result_t got);
        htks_pkg::result_t want;
        if (due_picks.size() == 0)
            report_mismatch($sformatf("unexpected pick: rank %0d shade %0d last %0b",
                                      got.rank, got.top_shade, got.last_result));
        else
        begin
            want = due_picks.pop_front();
            if (got.rank !== want.rank)
                report_mismatch($sformatf("rank %0d, expected %0d", got.rank, want.rank));
            if (got.top_shade !== want.top_shade)
                report_mismatch($sformatf("rank %0d: top_shade %0d, expected %0d",
                                          want.rank, got.top_shade, want.top_shade));
            if (got.last_result !== want.last_result)
                report_mismatch($sformatf("rank %0d: last_result %0b, expected %0b",
                                          want.rank, got.last_result, want.last_result));
        end
    endtask

    // Sample all channels at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < htks_pkg::NUM_BINS; j++)
                tally[j] = '0;
            pick_limit = htks_pkg::NUM_COLORS_RESET;
            due_picks.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_pick(out_data);
            if (in_valid && !in_stall)
                count_pixel(in_data);
            if (psel && penable && pwrite && pready
                && paddr[htks_pkg::PADDR_W-1:2] == htks_pkg::REG_NUM_COLORS)
                pick_limit = pwdata[htks_pkg::NCOL_W-1:0];
        end
        waiting = due_picks.size();
    end

endmodule

>>> tb/sv/histogram_top_k_shades_top_test.sv
// Testbench top for the histogram top-k shade selector: drives pixel and APB requests
// with random idling and gives the verdict. Depends on htks_pkg, htks_pick_checker
// and histogram_top_k_shades_top.
`timescale 1ns / 1ps

module histogram_top_k_shades_top_test;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int RANDOM_PIXELS = 90;
    localparam int IDLE_PERCENT  = 24;
    // Covers the clearing pass after the last pick.
    localparam int SETTLE_CYCLES = 300;
    // Covers more than two further picks, so a stray pick would show.
    localparam int DRAIN_CYCLES  = 600;

    localparam logic [htks_pkg::PADDR_W-1:0] ADDR_NUM_COLORS =
        {htks_pkg::REG_NUM_COLORS, 2'b00};
    localparam logic [htks_pkg::PADDR_W-1:0] ADDR_UNMAPPED =
        {~htks_pkg::REG_NUM_COLORS, 2'b00};

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    htks_pkg::pixel_t               in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    htks_pkg::result_t              out_data;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [htks_pkg::PADDR_W-1:0]   paddr     = '0;
    logic [htks_pkg::PDATA_W-1:0]   pwdata    = '0;
    logic [htks_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           calm      = 1'b0;
    int                             mismatches;
    int                             waiting;
    int                             cycles    = 0;

    always #1 clk = ~clk;

    histogram_top_k_shades_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    htks_pick_checker pick_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    // Random back-pressure on the pick channel, off during the calm stretch.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d picks outstanding", cycles, waiting);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one pixel request; entered and left at a falling edge.
    task automatic push_pixel(input logic [htks_pkg::SHADE_W-1:0] shade, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{shade: shade, last_pixel: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic apb_write(input logic [htks_pkg::PADDR_W-1:0] addr,
                             input logic [htks_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every predicted pick has come out and the bins are cleared.
    task automatic settle;
        in_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int                           sent;
        int                           len;
        int                           narrow;
        int                           pick_count;
        logic [htks_pkg::SHADE_W-1:0] base;
        logic [htks_pkg::SHADE_W-1:0] shade;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset pick count: ties resolve to the higher shade.
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd128, 1'b0);
        push_pixel(8'd7, 1'b1);

        // A write to an unmapped register leaves the pick count alone; a one-pixel
        // image then picks emptied bins from the top.
        settle;
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFE1);
        push_pixel(8'd0, 1'b1);

        // A pick count of zero gives one pick.
        settle;
        apb_write(ADDR_NUM_COLORS, 32'd0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b1);

        // The full pick count.
        settle;
        apb_write(ADDR_NUM_COLORS, 32'd16);
        push_pixel(8'd1, 1'b0);
        push_pixel(8'd2, 1'b0);
        push_pixel(8'd2, 1'b0);
        push_pixel(8'd3, 1'b0);
        push_pixel(8'd3, 1'b0);
        push_pixel(8'd3, 1'b0);
        push_pixel(8'd254, 1'b0);
        push_pixel(8'd128, 1'b1);

        // The largest register value saturates to the full pick count.
        settle;
        apb_write(ADDR_NUM_COLORS, 32'd31);
        push_pixel(8'd85, 1'b0);
        push_pixel(8'd170, 1'b0);
        push_pixel(8'd170, 1'b1);

        // Upper data bits are dropped: this sets one pick.
        settle;
        apb_write(ADDR_NUM_COLORS, 32'hFFFF_FFE1);
        push_pixel(8'd42, 1'b1);

        // Random images, some clustered on a few shades to make ties and deep ranks.
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(2) == 0)
            begin
                settle;
                if ($urandom_range(5) == 0)
                    apb_write(ADDR_UNMAPPED, $urandom());
                pick_count = $urandom_range(31);
                if ($urandom_range(1) == 0)
                    apb_write(ADDR_NUM_COLORS, ($urandom() & ~32'h1F) | 32'(pick_count));
                else
                    apb_write(ADDR_NUM_COLORS, 32'(pick_count));
            end
            calm   = (sent >= 40 && sent < 75);
            len    = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 2);
            narrow = $urandom_range(1);
            base   = htks_pkg::SHADE_W'($urandom_range(255));
            for (int k = 0; k < len; k++)
            begin
                shade = narrow ? base + htks_pkg::SHADE_W'($urandom_range(3))
                               : htks_pkg::SHADE_W'($urandom_range(255));
                push_pixel(shade, k == len - 1);
                sent++;
            end
        end
        calm = 1'b0;

        // Drain: every predicted pick, then a quiet stretch for strays.
        in_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
hdl/htks_pkg.sv
hdl/histogram_top_k_shades_top.sv
tb/sv/htks_pick_checker.sv
tb/sv/histogram_top_k_shades_top_test.sv
